// ===== design/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define CC20_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cc20 check failed");

// Next-cycle implication, disabled while reset is low.
`define CC20_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cc20 check failed");

// Same-cycle implication that also holds through reset.
`define CC20_ASSERT_ALW(name, clk, ante, cons) \
  name: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error("cc20 check failed");

`endif

// ===== design/cc20_pkg.sv =====
package cc20_pkg;

  // Stream payload widths: 32-bit data word plus 3-bit byte count, padded to bytes.
  localparam int DATA_W     = 32;
  localparam int CNT_W      = 3;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 40;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  // One ChaCha block of sixteen 32-bit words, word 0 in the low bits.
  typedef logic [15:0][31:0] blk_t;

  // The four fixed words that open every block ("expand 32-byte k").
  localparam logic [3:0][31:0] SIGMA = {
    32'h6b206574, 32'h79622d32, 32'h3320646e, 32'h61707865
  };

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY0      = 3'd0,
    REG_KEY1      = 3'd1,
    REG_KEY2      = 3'd2,
    REG_KEY3      = 3'd3,
    REG_NONCE0    = 3'd4,
    REG_NONCE1    = 3'd5,
    REG_START_CTR = 3'd6
  } cfg_reg_t;

  // The four add-xor-rotate steps of a quarter round.
  typedef enum logic [1:0] {
    QR_AD16 = 2'd0,
    QR_CB12 = 2'd1,
    QR_AD8  = 2'd2,
    QR_CB7  = 2'd3
  } qr_step_t;

  // Request from the stream control to the block generator.
  typedef struct packed {
    logic        start;
    logic [31:0] counter;
  } gen_ctl_t;

  // Fixed left rotation belonging to each step.
  function automatic logic [31:0] qr_rot(qr_step_t code, logic [31:0] v);
    logic [31:0] r;
    unique case (code)
      QR_AD16: r = {v[15:0], v[31:16]};
      QR_CB12: r = {v[19:0], v[31:20]};
      QR_AD8:  r = {v[23:0], v[31:24]};
      QR_CB7:  r = {v[24:0], v[31:25]};
      default: r = v;
    endcase
    return r;
  endfunction

endpackage

// ===== design/cc20_step_unit.sv =====
module cc20_step_unit (
  input  cc20_pkg::blk_t     work_i,
  input  cc20_pkg::qr_step_t step_i,
  input  logic               diag_i,
  output cc20_pkg::blk_t     work_o
);
  import cc20_pkg::*;

  blk_t g;
  blk_t h;
  logic is_cd;

  assign is_cd = (step_i == QR_CB12) || (step_i == QR_CB7);

  // Diagonal rounds are gathered into column order, so the lanes stay fixed.
  for (genvar i = 0; i < 4; i++) begin : g_lane
    localparam int B_D = 4 + ((i + 1) & 3);
    localparam int C_D = 8 + ((i + 2) & 3);
    localparam int D_D = 12 + ((i + 3) & 3);

    logic [31:0] a, b, c, d;
    logic [31:0] sum, mix, rot;

    assign a = work_i[i];
    assign b = diag_i ? work_i[B_D] : work_i[4 + i];
    assign c = diag_i ? work_i[C_D] : work_i[8 + i];
    assign d = diag_i ? work_i[D_D] : work_i[12 + i];

    // One adder per lane: a+b on the a/d steps, c+d on the c/b steps.
    assign sum = is_cd ? (c + d) : (a + b);
    assign mix = (is_cd ? b : d) ^ sum;
    assign rot = qr_rot(step_i, mix);

    assign h[i]      = is_cd ? a : sum;
    assign h[4 + i]  = is_cd ? rot : b;
    assign h[8 + i]  = is_cd ? sum : c;
    assign h[12 + i] = is_cd ? d : rot;
  end

  // Scatter back into place, undoing the diagonal gather.
  for (genvar j = 0; j < 4; j++) begin : g_back
    assign work_o[j]      = h[j];
    assign work_o[4 + j]  = diag_i ? h[4 + ((j + 3) & 3)] : h[4 + j];
    assign work_o[8 + j]  = diag_i ? h[8 + ((j + 2) & 3)] : h[8 + j];
    assign work_o[12 + j] = diag_i ? h[12 + ((j + 1) & 3)] : h[12 + j];
  end

endmodule

// ===== design/cc20_block_gen.sv =====
module cc20_block_gen #(
  parameter int DOUBLE_ROUNDS = 10
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cc20_pkg::gen_ctl_t ctl,
  input  logic [7:0][31:0]   key_words,
  input  logic [2:0][31:0]   nonce_words,
  output logic               done,
  output cc20_pkg::blk_t     ks_words
);
  import cc20_pkg::*;

  localparam int STEPS = 8 * DOUBLE_ROUNDS;
  localparam int SW    = $clog2(STEPS);
  localparam logic [SW-1:0] LAST_STEP = SW'(STEPS - 1);

  typedef enum logic [2:0] {
    G_IDLE = 3'b001,
    G_RUN  = 3'b010,
    G_ADD  = 3'b100
  } gen_state_t;

  gen_state_t    state_r, state_nxt;
  logic [SW-1:0] step_r, step_nxt;
  blk_t          work_r, work_nxt;
  blk_t          init;
  blk_t          stepped;

  // Block input: constants, key, counter, nonce.
  always_comb begin
    init[3:0]   = SIGMA;
    init[11:4]  = key_words;
    init[12]    = ctl.counter;
    init[15:13] = nonce_words;
  end

  // The shared step unit: four lanes, one add-xor-rotate each per cycle.
  cc20_step_unit u_step (
    .work_i (work_r),
    .step_i (qr_step_t'(step_r[1:0])),
    .diag_i (step_r[2]),
    .work_o (stepped)
  );

  // Sequencer: load, 8 steps per double round, then the feed-forward add.
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    work_nxt  = work_r;
    done      = 1'b0;
    unique case (state_r)
      G_IDLE: begin
        if (ctl.start) begin
          work_nxt  = init;
          step_nxt  = '0;
          state_nxt = G_RUN;
        end
      end
      G_RUN: begin
        work_nxt = stepped;
        step_nxt = step_r + 1'b1;
        if (step_r == LAST_STEP) begin
          state_nxt = G_ADD;
        end
      end
      G_ADD: begin
        for (int i = 0; i < 16; i++) begin
          work_nxt[i] = work_r[i] + init[i];
        end
        done      = 1'b1;
        state_nxt = G_IDLE;
      end
      default: state_nxt = G_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= G_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  // Working words double as the keystream store once the add is done.
  always_ff @(posedge clk) begin
    work_r <= work_nxt;
  end

  assign ks_words = work_r;

endmodule

// ===== design/chacha20_stream_cipher.sv =====
// ChaCha20 stream cipher, one 32-bit word per request.
// Input stream: in_tdata carries a data word and its byte count, in_tlast ends
// a message. Each word comes back on the output stream XORed with the next
// keystream word; bytes past the byte count are zero, count and last are copied.
// Key, nonce and start counter are written on the cfg port, by the user only
// while the block idles; the block itself does not enforce this. The first
// word of a message, and every sixteenth word after it, starts a new 64-byte
// keystream block on the shared quarter-round step unit: 8 steps per double
// round, then the feed-forward add, before the word is delivered. Other words
// appear the cycle after acceptance when the output register is free, and a new
// request is taken every cycle while the output moves.
// in_tready is low while a block is being generated and while a result waits
// behind a held output register. A stalled receiver holds out_tdata steady; one
// more request is taken into the output register's shadow before input stalls.
// Reset clears the control state and the configuration registers; the next word
// starts a new message.
module chacha20_stream_cipher #(
  parameter int DOUBLE_ROUNDS = 10
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // Input stream. in_tdata: in_data [31:0], byte_count [34:32], zero pad.
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [cc20_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  logic                               in_tlast,
  // Output stream. out_tdata: out_data [31:0], out_byte_count [34:32], zero pad.
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [cc20_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic                               out_tlast,
  // Configuration writes.
  input  logic                               cfg_we,
  input  logic [cc20_pkg::CFG_IDX_W-1:0]     cfg_addr,
  input  logic [cc20_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import cc20_pkg::*;

  typedef enum logic [2:0] {
    T_IDLE = 3'b001,
    T_GEN  = 3'b010,
    T_OUT  = 3'b100
  } top_state_t;

  // Configuration registers.
  logic [63:0] key0_r, key1_r, key2_r, key3_r, nonce0_r;
  logic [31:0] nonce1_r, start_ctr_r;

  // Message state.
  top_state_t  state_r, state_nxt;
  logic        in_msg_r, in_msg_nxt;
  logic [3:0]  pos_r, pos_nxt;
  logic [31:0] ctr_r, ctr_nxt;

  // Held request while a block is generated or the output is full.
  logic [31:0]      data_r, data_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             last_r, last_nxt;

  // Output register.
  logic             out_valid_r, out_valid_nxt;
  logic [31:0]      out_data_r, out_data_nxt;
  logic [CNT_W-1:0] out_cnt_r, out_cnt_nxt;
  logic             out_last_r, out_last_nxt;

  logic             in_acc, out_free, use_in, fin;
  logic [3:0]       eff_pos, fin_pos;
  logic [31:0]      eff_ctr, fin_data, ks_word, mask;
  logic [CNT_W-1:0] fin_cnt;
  logic             fin_last;
  gen_ctl_t         gen_ctl;
  logic             gen_done;
  blk_t             ks_words;

  // Register writes; indexes past the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key0_r      <= '0;
      key1_r      <= '0;
      key2_r      <= '0;
      key3_r      <= '0;
      nonce0_r    <= '0;
      nonce1_r    <= '0;
      start_ctr_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_KEY0:      key0_r      <= cfg_wdata;
        REG_KEY1:      key1_r      <= cfg_wdata;
        REG_KEY2:      key2_r      <= cfg_wdata;
        REG_KEY3:      key3_r      <= cfg_wdata;
        REG_NONCE0:    nonce0_r    <= cfg_wdata;
        REG_NONCE1:    nonce1_r    <= cfg_wdata[31:0];
        REG_START_CTR: start_ctr_r <= cfg_wdata[31:0];
        default: ;
      endcase
    end
  end

  cc20_block_gen #(
    .DOUBLE_ROUNDS (DOUBLE_ROUNDS)
  ) u_gen (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (gen_ctl),
    .key_words   ({key3_r, key2_r, key1_r, key0_r}),
    .nonce_words ({nonce1_r, nonce0_r}),
    .done        (gen_done),
    .ks_words    (ks_words)
  );

  assign in_tready = (state_r == T_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign use_in    = (state_r == T_IDLE);

  // A new message restarts the position and loads the start counter.
  assign eff_pos = in_msg_r ? pos_r : 4'd0;
  assign eff_ctr = in_msg_r ? ctr_r : start_ctr_r;

  // The finishing word comes straight from the input or from the held request.
  assign fin_data = use_in ? in_tdata[31:0] : data_r;
  assign fin_cnt  = use_in ? in_tdata[34:32] : cnt_r;
  assign fin_last = use_in ? in_tlast : last_r;
  assign fin_pos  = use_in ? eff_pos : pos_r;
  assign ks_word  = ks_words[fin_pos];

  // Valid-byte mask; counts above four keep all bytes.
  always_comb begin
    case (fin_cnt)
      3'd0:    mask = 32'h0000_0000;
      3'd1:    mask = 32'h0000_00ff;
      3'd2:    mask = 32'h0000_ffff;
      3'd3:    mask = 32'h00ff_ffff;
      default: mask = 32'hffff_ffff;
    endcase
  end

  // The block start rides on the accepting edge.
  always_comb begin
    gen_ctl.start   = in_acc && (eff_pos == 4'd0);
    gen_ctl.counter = use_in ? eff_ctr : ctr_r;
  end

  // Stream control.
  always_comb begin
    state_nxt     = state_r;
    in_msg_nxt    = in_msg_r;
    pos_nxt       = pos_r;
    ctr_nxt       = ctr_r;
    data_nxt      = data_r;
    cnt_nxt       = cnt_r;
    last_nxt      = last_r;
    out_data_nxt  = out_data_r;
    out_cnt_nxt   = out_cnt_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_valid_r && !out_tready;
    fin           = 1'b0;

    unique case (state_r)
      T_IDLE: begin
        if (in_acc) begin
          data_nxt   = in_tdata[31:0];
          cnt_nxt    = in_tdata[34:32];
          last_nxt   = in_tlast;
          in_msg_nxt = 1'b1;
          pos_nxt    = eff_pos;
          ctr_nxt    = eff_ctr;
          if (eff_pos == 4'd0) begin
            state_nxt = T_GEN;
          end else if (out_free) begin
            fin = 1'b1;
          end else begin
            state_nxt = T_OUT;
          end
        end
      end
      T_GEN: begin
        if (gen_done) begin
          ctr_nxt   = ctr_r + 32'd1;
          state_nxt = T_OUT;
        end
      end
      T_OUT: begin
        if (out_free) begin
          fin       = 1'b1;
          state_nxt = T_IDLE;
        end
      end
      default: state_nxt = T_IDLE;
    endcase

    // Deliver one word and step the keystream position.
    if (fin) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = (fin_data ^ ks_word) & mask;
      out_cnt_nxt   = fin_cnt;
      out_last_nxt  = fin_last;
      pos_nxt       = fin_pos + 4'd1;
      if (fin_last) begin
        in_msg_nxt = 1'b0;
        pos_nxt    = 4'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= T_IDLE;
      in_msg_r    <= 1'b0;
      pos_r       <= '0;
      ctr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_msg_r    <= in_msg_nxt;
      pos_r       <= pos_nxt;
      ctr_r       <= ctr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r     <= data_nxt;
    cnt_r      <= cnt_nxt;
    last_r     <= last_nxt;
    out_data_r <= out_data_nxt;
    out_cnt_r  <= out_cnt_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_cnt_r, out_data_r};
  assign out_tlast  = out_last_r;

endmodule

// ===== design/cc20_checker.sv =====
`include "assert_macros.svh"

module cc20_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [cc20_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                             out_tlast
);
  import cc20_pkg::*;

  // No result is shown in the first cycle after reset is released.
  `CC20_ASSERT_ALW(a_quiet_after_reset, clk, rst_n && $past(!rst_n), !out_tvalid)

  // A stalled result stays put.
  `CC20_ASSERT_NXT(a_stall_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast))

  // A zero byte count gives an all-zero word.
  `CC20_ASSERT_IMP(a_zero_count, clk, rst_n, out_tvalid && out_tdata[34:32] == 3'd0, out_tdata[31:0] == 32'd0)

  // A one-byte word has its upper three bytes cleared.
  `CC20_ASSERT_IMP(a_one_byte, clk, rst_n, out_tvalid && out_tdata[34:32] == 3'd1, out_tdata[31:8] == 24'd0)

  // The pad above the byte count is always zero.
  `CC20_ASSERT_IMP(a_pad_zero, clk, rst_n, out_tvalid, out_tdata[OUT_TDATA_W-1:35] == 5'd0)

endmodule

bind chacha20_stream_cipher cc20_checker u_cc20_checker (.*);

// ===== tb/cipher_word_checker.sv =====
`timescale 1ns / 100ps

// Watches the configuration port and both streams of the ChaCha20 stream cipher.
// It keeps its own copy of the key, nonce and counter registers and of the
// keystream state. Each accepted request yields one expected cipher word, and
// each word the block delivers is compared with the oldest expectation.
module cipher_word_checker
  import cc20_pkg::*;
#(
  parameter int DOUBLE_ROUNDS = 10
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   in_tlast,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   out_tlast,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  output int                     mismatch_count,
  output int                     words_pending
);

  typedef struct {
    logic [DATA_W-1:0] data;
    logic [CNT_W-1:0]  byte_count;
    logic              last;
  } cipher_word_t;

  // Shadow copy of the configuration registers.
  logic [63:0] key_regs [4];
  logic [63:0] nonce_low;
  logic [31:0] nonce_high;
  logic [31:0] counter_start;

  // Keystream state between requests.
  blk_t        keystream;
  logic [3:0]  word_index;
  logic [31:0] block_count;
  logic        message_open;

  cipher_word_t expected_words [$];

  function automatic logic [31:0] rotl32(logic [31:0] v, int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic void quarter_round(inout blk_t s, input int a, int b, int c, int d);
    s[a] = s[a] + s[b]; s[d] = rotl32(s[d] ^ s[a], 16);
    s[c] = s[c] + s[d]; s[b] = rotl32(s[b] ^ s[c], 12);
    s[a] = s[a] + s[b]; s[d] = rotl32(s[d] ^ s[a], 8);
    s[c] = s[c] + s[d]; s[b] = rotl32(s[b] ^ s[c], 7);
  endfunction

  // One 64-byte keystream block for the given block counter.
  function automatic blk_t keystream_block(logic [31:0] ctr);
    blk_t init;
    blk_t mix;
    for (int i = 0; i < 4; i++) begin
      init[i]         = SIGMA[i];
      init[4 + 2 * i] = key_regs[i][31:0];
      init[5 + 2 * i] = key_regs[i][63:32];
    end
    init[12] = ctr;
    init[13] = nonce_low[31:0];
    init[14] = nonce_low[63:32];
    init[15] = nonce_high;
    mix = init;
    for (int r = 0; r < DOUBLE_ROUNDS; r++) begin
      quarter_round(mix, 0, 4, 8, 12);
      quarter_round(mix, 1, 5, 9, 13);
      quarter_round(mix, 2, 6, 10, 14);
      quarter_round(mix, 3, 7, 11, 15);
      quarter_round(mix, 0, 5, 10, 15);
      quarter_round(mix, 1, 6, 11, 12);
      quarter_round(mix, 2, 7, 8, 13);
      quarter_round(mix, 3, 4, 9, 14);
    end
    for (int i = 0; i < 16; i++) begin
      mix[i] = mix[i] + init[i];
    end
    return mix;
  endfunction

  always @(posedge clk) begin
    cipher_word_t want;
    logic [31:0]  valid_mask;
    logic [2:0]   count;
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) key_regs[i] = '0;
      nonce_low      = '0;
      nonce_high     = '0;
      counter_start  = '0;
      keystream      = '0;
      word_index     = '0;
      block_count    = '0;
      message_open   = 1'b0;
      mismatch_count = 0;
      expected_words.delete();
    end else begin
      // Register writes; an index outside the map is dropped.
      if (cfg_we) begin
        case (cfg_addr)
          REG_KEY0:      key_regs[0]   = cfg_wdata;
          REG_KEY1:      key_regs[1]   = cfg_wdata;
          REG_KEY2:      key_regs[2]   = cfg_wdata;
          REG_KEY3:      key_regs[3]   = cfg_wdata;
          REG_NONCE0:    nonce_low     = cfg_wdata;
          REG_NONCE1:    nonce_high    = cfg_wdata[31:0];
          REG_START_CTR: counter_start = cfg_wdata[31:0];
          default: ;
        endcase
      end

      // An accepted request predicts one cipher word.
      if (in_tvalid && in_tready) begin
        if (!message_open) begin
          block_count  = counter_start;
          word_index   = '0;
          message_open = 1'b1;
        end
        if (word_index == 0) begin
          keystream   = keystream_block(block_count);
          block_count = block_count + 32'd1;
        end
        count = in_tdata[DATA_W +: CNT_W];
        case (count)
          3'd0:    valid_mask = 32'h0000_0000;
          3'd1:    valid_mask = 32'h0000_00ff;
          3'd2:    valid_mask = 32'h0000_ffff;
          3'd3:    valid_mask = 32'h00ff_ffff;
          default: valid_mask = 32'hffff_ffff;
        endcase
        want.data       = (in_tdata[DATA_W-1:0] ^ keystream[word_index]) & valid_mask;
        want.byte_count = count;
        want.last       = in_tlast;
        word_index      = word_index + 4'd1;
        if (in_tlast) begin
          message_open = 1'b0;
          word_index   = '0;
        end
        expected_words.push_back(want);
      end

      // Compare each delivered word with the oldest prediction.
      if (out_tvalid && out_tready) begin
        if (expected_words.size() == 0) begin
          $error("unexpected output word %h (last %b)", out_tdata, out_tlast);
          mismatch_count++;
        end else begin
          want = expected_words.pop_front();
          if (out_tdata[DATA_W-1:0] !== want.data) begin
            $error("out_data mismatch: expected %h, got %h",
                   want.data, out_tdata[DATA_W-1:0]);
            mismatch_count++;
          end
          if (out_tdata[DATA_W +: CNT_W] !== want.byte_count) begin
            $error("out_byte_count mismatch: expected %0d, got %0d",
                   want.byte_count, out_tdata[DATA_W +: CNT_W]);
            mismatch_count++;
          end
          if (out_tlast !== want.last) begin
            $error("out_last mismatch: expected %b, got %b", want.last, out_tlast);
            mismatch_count++;
          end
        end
      end
    end
    words_pending = expected_words.size();
  end

endmodule

// ===== tb/tb_chacha20_stream_cipher.sv =====
`timescale 1ns / 100ps

module tb_chacha20_stream_cipher;
  import cc20_pkg::*;

  localparam int ROUNDS        = 10;
  localparam int TOTAL_WORDS   = 1470;
  localparam int PHASE_WORDS   = 100;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 200;

  // Ways to fill the registers at the start of a phase.
  localparam int CFG_RANDOM      = 0;
  localparam int CFG_ALL_ONES    = 1;
  localparam int CFG_ZERO_WRAP   = 2;
  localparam int CFG_RANDOM_PLUS = 3;

  // Index past the register map; writes to it must be dropped.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  logic clk;
  logic rst_n = 1'b0;

  // in_tdata: in_data [31:0], byte_count [34:32], zero pad.
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata  = '0;
  logic                   in_tlast  = 1'b0;
  // out_tdata: out_data [31:0], out_byte_count [34:32], zero pad.
  logic                   out_tvalid;
  logic                   out_tready = 1'b1;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  logic                   cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_addr  = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  int mismatch_count;
  int words_pending;
  int words_sent    = 0;
  int hold_requests = 0;
  bit steady_flow   = 1'b0;

  chacha20_stream_cipher #(
    .DOUBLE_ROUNDS (ROUNDS)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  cipher_word_checker #(
    .DOUBLE_ROUNDS (ROUNDS)
  ) checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tlast       (in_tlast),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tlast      (out_tlast),
    .cfg_we         (cfg_we),
    .cfg_addr       (cfg_addr),
    .cfg_wdata      (cfg_wdata),
    .mismatch_count (mismatch_count),
    .words_pending  (words_pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Offer one word, with an occasional idle cycle first, until it is taken.
  task automatic send_word(input logic [31:0] data, input logic [2:0] count,
                           input logic last);
    @(negedge clk);
    while (!steady_flow && $urandom_range(99) < 6) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = {{(IN_TDATA_W - DATA_W - CNT_W){1'b0}}, count, data};
    in_tlast  = last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    words_sent++;
  endtask

  // A run of random words; full words dominate, odd counts show up now and then.
  task automatic send_message(input int len, input bit close);
    logic [31:0] data;
    logic [2:0]  count;
    bit          final_word;
    for (int i = 0; i < len; i++) begin
      final_word = close && (i == len - 1);
      case ($urandom_range(15))
        0:       data = 32'h0000_0000;
        1:       data = 32'hffff_ffff;
        default: data = $urandom;
      endcase
      if (final_word)
        count = ($urandom_range(9) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(1, 4));
      else
        count = ($urandom_range(15) == 0) ? 3'($urandom_range(7)) : 3'd4;
      send_word(data, count, final_word);
    end
  endtask

  // Stop offering and wait until every predicted word has come back.
  task automatic drain_results();
    @(negedge clk);
    in_tvalid = 1'b0;
    wait (words_pending == 0);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_addr  = idx;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  function automatic logic [63:0] setting_value(int style, bit counter_reg);
    case (style)
      CFG_ALL_ONES:  return '1;
      CFG_ZERO_WRAP: return counter_reg ? 64'h0000_0000_ffff_fffe : '0;
      default:       return {$urandom, $urandom};
    endcase
  endfunction

  task automatic load_settings(input int style);
    write_reg(REG_KEY0,      setting_value(style, 1'b0));
    write_reg(REG_KEY1,      setting_value(style, 1'b0));
    write_reg(REG_KEY2,      setting_value(style, 1'b0));
    write_reg(REG_KEY3,      setting_value(style, 1'b0));
    write_reg(REG_NONCE0,    setting_value(style, 1'b0));
    write_reg(REG_NONCE1,    setting_value(style, 1'b0));
    write_reg(REG_START_CTR, setting_value(style, 1'b1));
    if (style == CFG_RANDOM_PLUS) write_reg(REG_UNUSED, {$urandom, $urandom});
  endtask

  // Result side: random back-pressure, plus long hold-offs when requested.
  initial begin : receiver
    int hold_served;
    int stall_left;
    hold_served = 0;
    stall_left  = 0;
    forever begin
      @(negedge clk);
      if (hold_requests > hold_served) begin
        hold_served++;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        out_tready = 1'b0;
        stall_left--;
      end else begin
        out_tready = !(!steady_flow && $urandom_range(99) < 6);
      end
    end
  end

  initial begin : watchdog
    #10ms;
    $display("chacha20_stream_cipher regression: fail");
    $finish;
  end

  initial begin : stimulus
    int phase;
    int phase_words;
    int msg_len;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // Directed words under the all-zero reset settings. The first message
    // crosses a block boundary and walks every byte count except one, including a
    // short word in mid-message, a zero count and the counts above four.
    send_word(32'h0000_0000, 3'd4, 1'b0);
    send_word(32'hffff_ffff, 3'd4, 1'b0);
    send_word(32'ha5a5_a5a5, 3'd4, 1'b0);
    send_word(32'h5a5a_5a5a, 3'd4, 1'b0);
    send_word(32'hffff_ffff, 3'd2, 1'b0);
    send_word(32'hffff_ffff, 3'd0, 1'b0);
    send_word(32'h1234_5678, 3'd5, 1'b0);
    send_word(32'h9abc_def0, 3'd6, 1'b0);
    send_word(32'hffff_ffff, 3'd7, 1'b0);
    for (int i = 0; i < 7; i++) send_word($urandom, 3'd4, 1'b0);
    send_word(32'hffff_ffff, 3'd3, 1'b1);
    // A one-word message, then a two-word one ending on a partial word.
    send_word(32'hffff_ffff, 3'd1, 1'b1);
    send_word(32'h0000_0000, 3'd4, 1'b0);
    send_word(32'hffff_ffff, 3'd2, 1'b1);
    drain_results();

    // Random phases, each under fresh settings. Some phases end with a message
    // left open, so the next settings land in the middle of that message.
    for (phase = 0; words_sent < TOTAL_WORDS; phase++) begin
      load_settings(phase % 4);
      steady_flow = (phase == 2);
      if (phase == 1 || phase == 6) hold_requests++;
      phase_words = 0;
      while (phase_words < PHASE_WORDS) begin
        msg_len = ($urandom_range(9) == 0) ? $urandom_range(33, 70) : $urandom_range(1, 24);
        send_message(msg_len, 1'b1);
        phase_words += msg_len;
      end
      if (phase % 3 == 1) send_message($urandom_range(5, 25), 1'b0);
      drain_results();
    end
    steady_flow = 1'b0;

    repeat (SETTLE_CYCLES) @(negedge clk);
    if (words_pending != 0) $error("%0d predicted words never arrived", words_pending);
    if (mismatch_count == 0 && words_pending == 0) begin
      $display("chacha20_stream_cipher regression: pass");
    end else begin
      $display("chacha20_stream_cipher regression: fail");
    end
    $finish;
  end

endmodule
